>>> design/vdm_pkg.sv
// vdm_pkg: shared types and constants of the vector distance metric unit
// no dependencies
`default_nettype none
package vdm_pkg;
  localparam int unsigned ACC_W = 48;
  localparam int unsigned OUT_W = 32;

  typedef enum logic [1:0] {
    MODE_EUCLID = 2'd0,
    MODE_MANHAT = 2'd1,
    MODE_CHEBY  = 2'd2,
    MODE_CANB   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_ACC, ST_SQRT, ST_OUT
  } state_e;

  typedef struct packed {
    logic load;       // latch input pair, compute magnitudes
    logic div_start;  // start canberra divide
    logic div_step;   // one divide iteration
    logic acc_upd;    // fold term into accumulator
    logic sqrt_start; // load root unit
    logic sqrt_step;  // one root iteration
    logic out_load;   // form result into output register
  } ctrl_t;

  typedef struct packed {
    logic is_last;
    logic div_done;
    logic sqrt_done;
  } stat_t;
endpackage
`default_nettype wire

>>> design/vector_distance_metric_unit.sv
// vector_distance_metric_unit: top level, config register, controller, datapath
// depends on vdm_pkg, vdm_ctrl, vdm_datapath
//
// usage
//   s_axis carries one element pair per item: tdata = {elem_b, elem_a},
//   tlast marks the final pair. m_axis returns one item per vector:
//   tdata = distance (unsigned, 8 fraction bits, canberra 16), tuser = saturated.
//   cfg channel writes metric_mode (0 euclid, 1 manhattan, 2 chebyshev,
//   3 canberra); write only while idle.
// sequence
//   one item at a time: each pair is latched, then folded into the
//   accumulator; canberra pairs first run the bit-serial quotient divider
//   the final pair then loads the output register, euclid first runs
//   the one-bit-per-cycle square root
//   a vector longer than MAX_LEN closes on its MAX_LEN-th pair
// reset
//   async active low: mode euclid, accumulator, overflow and count cleared
// stalls
//   a held result sits in the output register; the next vector's pairs
//   keep flowing and only its own result waits for the register to free
`default_nettype none
module vector_distance_metric_unit #(
  parameter int unsigned MAX_LEN   = 256,
  parameter int unsigned ELEM_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [1:0]               cfg_data_i,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire logic [2*ELEM_BITS-1:0]   s_axis_tdata,  // elem_a, elem_b
  input  wire logic                     s_axis_tlast,  // last_elem
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  output logic [31:0]                   m_axis_tdata,  // distance
  output logic                          m_axis_tuser   // saturated
);
  logic [1:0] mode_q;
  vdm_pkg::ctrl_t ctrl;
  vdm_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= vdm_pkg::MODE_EUCLID;
    else if (cfg_valid_i) mode_q <= cfg_data_i;
  end

  vdm_ctrl u_ctrl (
    .clk_i, .rst_ni, .mode_i(mode_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .stat_i(stat), .ctrl_o(ctrl)
  );

  vdm_datapath #(.MAX_LEN(MAX_LEN), .ELEM_BITS(ELEM_BITS)) u_dp (
    .clk_i, .rst_ni, .mode_i(mode_q),
    .a_i(s_axis_tdata[ELEM_BITS-1:0]), .b_i(s_axis_tdata[2*ELEM_BITS-1:ELEM_BITS]),
    .last_i(s_axis_tlast), .ctrl_i(ctrl), .stat_o(stat),
    .dist_o(m_axis_tdata), .sat_o(m_axis_tuser)
  );
endmodule
`default_nettype wire

>>> design/vdm_datapath.sv
// vdm_datapath: term generation, restoring divider, root unit, accumulator
// depends on vdm_pkg
`default_nettype none
module vdm_datapath #(
  parameter int unsigned MAX_LEN   = 256,
  parameter int unsigned ELEM_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [1:0]            mode_i,
  input  wire logic [ELEM_BITS-1:0]  a_i,
  input  wire logic [ELEM_BITS-1:0]  b_i,
  input  wire logic                  last_i,
  input  wire vdm_pkg::ctrl_t        ctrl_i,
  output vdm_pkg::stat_t             stat_o,
  output logic [31:0]                dist_o,
  output logic                       sat_o
);
  localparam int unsigned MW  = ELEM_BITS + 1;       // magnitude width
  localparam int unsigned NW  = MW + 16;             // dividend width
  localparam int unsigned CW  = $clog2(MAX_LEN + 1);
  localparam int unsigned DCW = $clog2(NW + 1);
  localparam logic [47:0] ACC_MAX = {48{1'b1}};

  logic signed [ELEM_BITS:0] sa, sb, sd;
  logic [MW-1:0] d_q, d_d, den_q, den_d;
  logic [MW-1:0] ma, mb;
  logic [CW-1:0] cnt_q;
  logic last_q;

  assign sa = {a_i[ELEM_BITS-1], a_i};
  assign sb = {b_i[ELEM_BITS-1], b_i};
  assign sd = sa - sb;
  assign ma = sa[ELEM_BITS] ? MW'(-sa) : MW'(sa);
  assign mb = sb[ELEM_BITS] ? MW'(-sb) : MW'(sb);
  assign d_d = sd[ELEM_BITS] ? MW'(-sd) : MW'(sd);
  assign den_d = ma + mb;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      d_q   <= d_d;
      den_q <= den_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      last_q <= 1'b0;
    end else if (ctrl_i.load) begin
      last_q <= last_i || (cnt_q + CW'(1) >= CW'(MAX_LEN));
      cnt_q  <= (last_i || (cnt_q + CW'(1) >= CW'(MAX_LEN))) ? '0 : cnt_q + CW'(1);
    end
  end

  // restoring divider, one quotient bit per cycle
  // start coincides with the pair load, so the dividend comes from d_d
  logic [NW-1:0] quo_q, rem_q;
  logic [NW:0]   trial;
  logic [DCW-1:0] dcnt_q;
  assign trial = {rem_q, quo_q[NW-1]} - {{(NW+1-MW){1'b0}}, den_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dcnt_q <= '0;
    else if (ctrl_i.div_start) dcnt_q <= DCW'(NW);
    else if (ctrl_i.div_step && dcnt_q != '0) dcnt_q <= dcnt_q - DCW'(1);
  end
  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_start) begin
      quo_q <= {d_d, 16'd0};
      rem_q <= '0;
    end else if (ctrl_i.div_step) begin
      if (!trial[NW]) begin
        rem_q <= trial[NW-1:0];
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[NW-2:0], quo_q[NW-1]};
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
  end

  // per-pair term
  logic [47:0] term;
  always_comb begin
    case (mode_i)
      vdm_pkg::MODE_EUCLID: term = 48'(d_q) * 48'(d_q);
      vdm_pkg::MODE_CANB:   term = (den_q == '0) ? 48'd0 : 48'(quo_q);
      default:              term = 48'(d_q) << 8;
    endcase
  end

  logic [47:0] acc_q, acc_d;
  logic        ovf_q, ovf_d;
  logic [48:0] sum;
  assign sum = {1'b0, acc_q} + {1'b0, term};
  always_comb begin
    acc_d = acc_q;
    ovf_d = ovf_q;
    if (ctrl_i.out_load) begin
      acc_d = '0;
      ovf_d = 1'b0;
    end else if (ctrl_i.acc_upd) begin
      if (mode_i == vdm_pkg::MODE_CHEBY) begin
        if (term > acc_q) acc_d = term;
      end else if (sum[48]) begin
        acc_d = ACC_MAX;
        ovf_d = 1'b1;
      end else begin
        acc_d = sum[47:0];
      end
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      ovf_q <= ovf_d;
    end
  end

  // bit-pair square root of acc << 16, one result bit per cycle
  // loaded from the accumulator value that includes the final term
  logic [63:0] sx_q;
  logic [31:0] root_q;
  logic [33:0] srem_q;
  logic [5:0]  scnt_q;
  logic [33:0] strial;
  assign strial = {srem_q[31:0], sx_q[63:62]} - {root_q, 2'b01};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) scnt_q <= '0;
    else if (ctrl_i.sqrt_start) scnt_q <= 6'd32;
    else if (ctrl_i.sqrt_step && scnt_q != '0) scnt_q <= scnt_q - 6'd1;
  end
  always_ff @(posedge clk_i) begin
    if (ctrl_i.sqrt_start) begin
      sx_q   <= {acc_d, 16'd0};
      root_q <= '0;
      srem_q <= '0;
    end else if (ctrl_i.sqrt_step) begin
      sx_q <= {sx_q[61:0], 2'b00};
      if (!strial[33]) begin
        srem_q <= strial;
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        srem_q <= {srem_q[31:0], sx_q[63:62]};
        root_q <= {root_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      if (mode_i == vdm_pkg::MODE_EUCLID) begin
        dist_o <= root_q;
        sat_o  <= ovf_q;
      end else if (acc_q[47:32] != '0) begin
        dist_o <= '1;
        sat_o  <= 1'b1;
      end else begin
        dist_o <= acc_q[31:0];
        sat_o  <= ovf_q;
      end
    end
  end

  assign stat_o.is_last   = last_q;
  assign stat_o.div_done  = (dcnt_q == DCW'(1));
  assign stat_o.sqrt_done = (scnt_q == 6'd1);
endmodule
`default_nettype wire

>>> design/vdm_ctrl.sv
// vdm_ctrl: sequencing state machine for the distance unit
// depends on vdm_pkg
`default_nettype none
module vdm_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [1:0]     mode_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire vdm_pkg::stat_t stat_i,
  output vdm_pkg::ctrl_t      ctrl_o
);
  vdm_pkg::state_e st_q, st_d;
  logic ov_q;
  logic out_free;

  assign out_free = !ov_q || out_ready_i;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      vdm_pkg::ST_IDLE: if (in_valid_i) st_d = (mode_i == vdm_pkg::MODE_CANB) ?
                                               vdm_pkg::ST_DIV : vdm_pkg::ST_ACC;
      vdm_pkg::ST_DIV:  if (stat_i.div_done) st_d = vdm_pkg::ST_ACC;
      vdm_pkg::ST_ACC:  if (!stat_i.is_last) st_d = vdm_pkg::ST_IDLE;
                        else if (mode_i == vdm_pkg::MODE_EUCLID) st_d = vdm_pkg::ST_SQRT;
                        else st_d = vdm_pkg::ST_OUT;
      vdm_pkg::ST_SQRT: if (stat_i.sqrt_done) st_d = vdm_pkg::ST_OUT;
      vdm_pkg::ST_OUT:  if (out_free) st_d = vdm_pkg::ST_IDLE;
      default:          st_d = vdm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    in_ready_o = 1'b0;
    unique case (st_q)
      vdm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        ctrl_o.load = in_valid_i;
        ctrl_o.div_start = in_valid_i;
      end
      vdm_pkg::ST_DIV:  ctrl_o.div_step = 1'b1;
      vdm_pkg::ST_ACC: begin
        ctrl_o.acc_upd = 1'b1;
        ctrl_o.sqrt_start = stat_i.is_last;
      end
      vdm_pkg::ST_SQRT: ctrl_o.sqrt_step = 1'b1;
      vdm_pkg::ST_OUT:  ctrl_o.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= vdm_pkg::ST_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (ctrl_o.out_load) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end
  assign out_valid_o = ov_q;
endmodule
`default_nettype wire
